### hdl/efc_pkg.sv
// ----------------------------------------------------------------------------
// efc_pkg
// Shared types, protocol constants and token tables for the frame classifier.
// ----------------------------------------------------------------------------
package efc_pkg;

    // Default byte count limit, counter saturates here
    localparam int MAX_FRAME_BYTES_DEF = 4095;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int MAC_W   = 48;
    localparam int ETYPE_W = 16;
    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int LEN_W   = 12;
    localparam int CLASS_W = 3;
    localparam int HDR_W   = 6;
    localparam int PSTART_W = 8;
    localparam int PROG_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HTTP_PORT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DNS_PORT  = 1'b1;

    // Configuration reset values
    localparam logic [PORT_W-1:0] HTTP_PORT_RST = 16'd80;
    localparam logic [PORT_W-1:0] DNS_PORT_RST  = 16'd53;

    // Ethertypes and IP protocol numbers
    localparam logic [ETYPE_W-1:0] ETH_ARP  = 16'h0806;
    localparam logic [ETYPE_W-1:0] ETH_IPV4 = 16'h0800;
    localparam logic [7:0] IPP_ICMP = 8'd1;
    localparam logic [7:0] IPP_TCP  = 8'd6;
    localparam logic [7:0] IPP_UDP  = 8'd17;

    // Header offsets and minimum lengths (bytes)
    localparam int ETH_HDR_LEN   = 14;
    localparam int MAC_DST_END   = 6;
    localparam int MAC_SRC_END   = 12;
    localparam int ARP_SPA_LO    = 28;
    localparam int ARP_SPA_HI    = 32;
    localparam int ARP_TPA_LO    = 38;
    localparam int ARP_TPA_HI    = 42;
    localparam int ARP_MIN_LEN   = 42;
    localparam int IP_PROTO_OFS  = 23;
    localparam int IP_SRC_LO     = 26;
    localparam int IP_SRC_HI     = 30;
    localparam int IP_DST_HI     = 34;
    localparam int IP_MIN_HDR    = 20;
    localparam int L4_SHORT_LEN  = 8;
    localparam int TCP_MIN_HDR   = 20;
    localparam int TCP_DOFF_OFS  = 12;
    localparam int LEN_SAT       = 4095;

    // Class codes
    localparam logic [CLASS_W-1:0] CLASS_DROP = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_ARP  = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_ICMP = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_TCP  = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_UDP  = 3'd4;
    localparam logic [CLASS_W-1:0] CLASS_HTTP = 3'd5;
    localparam logic [CLASS_W-1:0] CLASS_DNS  = 3'd6;

    // HTTP tokens: GET, POST, HTTP/1.1, HTTP/1.0
    localparam int NUM_TOK = 4;
    localparam int TOK_MAX = 8;
    localparam logic [BYTE_W-1:0] TOK_TEXT [NUM_TOK][TOK_MAX] = '{
        '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31},
        '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h30}
    };
    localparam logic [PROG_W-1:0] TOK_LEN [NUM_TOK] = '{4'd3, 4'd4, 4'd8, 4'd8};

    // Header fields of one finished frame, handed to the classifier
    typedef struct packed {
        logic [MAC_W-1:0]    dest_mac;
        logic [MAC_W-1:0]    source_mac;
        logic [ETYPE_W-1:0]  type_field;
        logic [HDR_W-1:0]    ip_hdr_bytes;
        logic [7:0]          ip_protocol;
        logic [IP_W-1:0]     src_addr;
        logic [IP_W-1:0]     dst_addr;
        logic [PORT_W-1:0]   src_port;
        logic [PORT_W-1:0]   dst_port;
        logic [PSTART_W-1:0] payload_start;
        logic                token_found;
    } frame_info_t;

endpackage

### hdl/efc_byte_if.sv
// ----------------------------------------------------------------------------
// efc_byte_if
// Byte stream channel: one frame byte and an end-of-frame mark per beat.
// ----------------------------------------------------------------------------
interface efc_byte_if;
    logic                          valid;
    logic                          ready;
    logic [efc_pkg::BYTE_W-1:0]    frame_byte;
    logic                          last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

### hdl/efc_result_if.sv
// ----------------------------------------------------------------------------
// efc_result_if
// Result channel: one classification beat per frame.
// ----------------------------------------------------------------------------
interface efc_result_if;
    logic                          valid;
    logic                          ready;
    logic [efc_pkg::CLASS_W-1:0]   pkt_class;
    logic [efc_pkg::MAC_W-1:0]     dest_mac;
    logic [efc_pkg::MAC_W-1:0]     source_mac;
    logic [efc_pkg::ETYPE_W-1:0]   type_field;
    logic [efc_pkg::IP_W-1:0]      source_ip;
    logic [efc_pkg::IP_W-1:0]      dest_ip;
    logic [efc_pkg::LEN_W-1:0]     frame_length;
    logic [efc_pkg::LEN_W-1:0]     app_length;

    modport source (output valid, output pkt_class, output dest_mac, output source_mac,
                    output type_field, output source_ip, output dest_ip,
                    output frame_length, output app_length, input ready);
    modport sink   (input valid, input pkt_class, input dest_mac, input source_mac,
                    input type_field, input source_ip, input dest_ip,
                    input frame_length, input app_length, output ready);
endinterface

### hdl/efc_token_search.sv
// ----------------------------------------------------------------------------
// efc_token_search
// Four parallel byte matchers looking for HTTP method/version tokens in the
// TCP payload, stopping at the first zero byte.
// ----------------------------------------------------------------------------
module efc_token_search
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       search_en,
    input  logic                       frame_end,
    input  logic [efc_pkg::BYTE_W-1:0] data,
    output logic                       found_now
);

    logic [efc_pkg::PROG_W-1:0] prog_reg  [efc_pkg::NUM_TOK];
    logic [efc_pkg::PROG_W-1:0] prog_next [efc_pkg::NUM_TOK];
    logic                       zero_seen_reg;
    logic                       zero_seen_next;
    logic                       found_reg;
    logic                       found_next;
    logic                       scan;
    logic [efc_pkg::NUM_TOK-1:0] hit;

    assign scan = search_en && !zero_seen_reg;

    // Per-token progress update
    always_comb
    begin
        for (int k = 0; k < efc_pkg::NUM_TOK; k++)
        begin
            hit[k]       = 1'b0;
            prog_next[k] = prog_reg[k];
            if (scan && (data != '0))
            begin
                if ((prog_reg[k] < efc_pkg::TOK_LEN[k]) &&
                    (data == efc_pkg::TOK_TEXT[k][prog_reg[k][2:0]]))
                begin
                    if ((prog_reg[k] + 4'd1) >= efc_pkg::TOK_LEN[k])
                    begin
                        hit[k]       = 1'b1;
                        prog_next[k] = '0;
                    end
                    else
                    begin
                        prog_next[k] = prog_reg[k] + 4'd1;
                    end
                end
                else if (data == efc_pkg::TOK_TEXT[k][0])
                begin
                    prog_next[k] = 4'd1;
                end
                else
                begin
                    prog_next[k] = '0;
                end
            end
        end
    end

    assign found_now      = found_reg || (|hit);
    assign zero_seen_next = zero_seen_reg || (scan && (data == '0));
    assign found_next     = found_now;

    // Matcher state, cleared at every frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < efc_pkg::NUM_TOK; k++)
            begin
                prog_reg[k] <= '0;
            end
            zero_seen_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else if (frame_end)
        begin
            for (int k = 0; k < efc_pkg::NUM_TOK; k++)
            begin
                prog_reg[k] <= '0;
            end
            zero_seen_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < efc_pkg::NUM_TOK; k++)
            begin
                prog_reg[k] <= prog_next[k];
            end
            zero_seen_reg <= zero_seen_next;
            found_reg     <= found_next;
        end
    end

endmodule

### hdl/efc_field_capture.sv
// ----------------------------------------------------------------------------
// efc_field_capture
// Input register, byte counter and header field capture. On the last byte
// the updated fields are latched into a frame snapshot for the classifier.
// ----------------------------------------------------------------------------
module efc_field_capture
#(
    parameter int MAX_FRAME_BYTES = efc_pkg::MAX_FRAME_BYTES_DEF,
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    efc_byte_if.sink              byte_in,
    input  logic                  snap_ready,
    output logic                  snap_valid,
    output efc_pkg::frame_info_t  snap_info,
    output logic [CW-1:0]         snap_len
);

    // Compare width: wide enough for the count and header offsets
    localparam int XW = (CW > 12) ? CW : 13;

    // Input register
    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic [efc_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       in_last_reg;
    logic                       consume;
    logic                       snap_room;

    // Per-frame header state
    logic [CW-1:0]                count_reg,  count_next;
    logic [efc_pkg::MAC_W-1:0]    mac0_reg,   mac0_next;
    logic [efc_pkg::MAC_W-1:0]    mac1_reg,   mac1_next;
    logic [efc_pkg::ETYPE_W-1:0]  ether_reg,  ether_next;
    logic [efc_pkg::HDR_W-1:0]    hdr_reg,    hdr_next;
    logic [7:0]                   proto_reg,  proto_next;
    logic [efc_pkg::IP_W-1:0]     addr0_reg,  addr0_next;
    logic [efc_pkg::IP_W-1:0]     addr1_reg,  addr1_next;
    logic [efc_pkg::PORT_W-1:0]   port0_reg,  port0_next;
    logic [efc_pkg::PORT_W-1:0]   port1_reg,  port1_next;
    logic [efc_pkg::PSTART_W-1:0] pstart_reg, pstart_next;

    // Snapshot register
    logic                 snap_valid_reg;
    logic                 snap_valid_next;
    efc_pkg::frame_info_t snap_info_reg;
    logic [CW-1:0]        snap_len_reg;

    logic          active;
    logic          frame_end;
    logic          search_en;
    logic          found_now;
    logic [XW-1:0] idx;
    logic [XW-1:0] l4_ofs;
    logic [XW-1:0] pstart_x;
    logic          is_arp;
    logic          is_ip;
    logic          ip_ok;
    logic [efc_pkg::BYTE_W-1:0] b;

    // Handshake: non-final bytes always drain, the final one needs snapshot room
    assign snap_room     = !snap_valid_reg || snap_ready;
    assign consume       = in_valid_reg && (!in_last_reg || snap_room);
    assign byte_in.ready = !in_valid_reg || consume;
    assign in_valid_next = (byte_in.valid && byte_in.ready) ? 1'b1 :
                           (consume ? 1'b0 : in_valid_reg);

    assign b         = in_byte_reg;
    assign frame_end = consume && in_last_reg;
    assign active    = consume && (count_reg < CW'(MAX_FRAME_BYTES));
    assign idx       = XW'(count_reg);
    assign l4_ofs    = XW'(efc_pkg::ETH_HDR_LEN) + XW'(hdr_reg);
    assign pstart_x  = XW'(pstart_reg);
    assign is_arp    = (ether_reg == efc_pkg::ETH_ARP);
    assign is_ip     = (ether_reg == efc_pkg::ETH_IPV4);
    assign ip_ok     = (idx > XW'(efc_pkg::ETH_HDR_LEN)) &&
                       (hdr_reg >= efc_pkg::HDR_W'(efc_pkg::IP_MIN_HDR));

    // Payload scan window for TCP
    assign search_en = active && (idx >= XW'(efc_pkg::ETH_HDR_LEN)) && is_ip && ip_ok &&
                       (proto_reg == efc_pkg::IPP_TCP) &&
                       (idx > l4_ofs + XW'(efc_pkg::TCP_DOFF_OFS)) &&
                       (pstart_x >= l4_ofs + XW'(efc_pkg::TCP_MIN_HDR)) &&
                       (idx >= pstart_x);

    // Field capture by byte position
    always_comb
    begin
        count_next  = count_reg;
        mac0_next   = mac0_reg;
        mac1_next   = mac1_reg;
        ether_next  = ether_reg;
        hdr_next    = hdr_reg;
        proto_next  = proto_reg;
        addr0_next  = addr0_reg;
        addr1_next  = addr1_reg;
        port0_next  = port0_reg;
        port1_next  = port1_reg;
        pstart_next = pstart_reg;
        if (active)
        begin
            count_next = count_reg + CW'(1);
            if (idx < XW'(efc_pkg::MAC_DST_END))
            begin
                mac0_next = {mac0_reg[efc_pkg::MAC_W-9:0], b};
            end
            else if (idx < XW'(efc_pkg::MAC_SRC_END))
            begin
                mac1_next = {mac1_reg[efc_pkg::MAC_W-9:0], b};
            end
            else if (idx < XW'(efc_pkg::ETH_HDR_LEN))
            begin
                ether_next = {ether_reg[7:0], b};
            end
            else if (is_arp)
            begin
                if ((idx >= XW'(efc_pkg::ARP_SPA_LO)) && (idx < XW'(efc_pkg::ARP_SPA_HI)))
                begin
                    addr0_next = {addr0_reg[efc_pkg::IP_W-9:0], b};
                end
                else if ((idx >= XW'(efc_pkg::ARP_TPA_LO)) &&
                         (idx < XW'(efc_pkg::ARP_TPA_HI)))
                begin
                    addr1_next = {addr1_reg[efc_pkg::IP_W-9:0], b};
                end
            end
            else if (is_ip)
            begin
                // IPv4 header fields
                if (idx == XW'(efc_pkg::ETH_HDR_LEN))
                begin
                    hdr_next = {b[3:0], 2'b00};
                end
                else if (idx == XW'(efc_pkg::IP_PROTO_OFS))
                begin
                    proto_next = b;
                end
                else if ((idx >= XW'(efc_pkg::IP_SRC_LO)) && (idx < XW'(efc_pkg::IP_SRC_HI)))
                begin
                    addr0_next = {addr0_reg[efc_pkg::IP_W-9:0], b};
                end
                else if ((idx >= XW'(efc_pkg::IP_SRC_HI)) && (idx < XW'(efc_pkg::IP_DST_HI)))
                begin
                    addr1_next = {addr1_reg[efc_pkg::IP_W-9:0], b};
                end
                // Transport header fields
                if (ip_ok)
                begin
                    if ((idx >= l4_ofs) && (idx < l4_ofs + XW'(2)))
                    begin
                        port0_next = {port0_reg[7:0], b};
                    end
                    else if ((idx >= l4_ofs + XW'(2)) && (idx < l4_ofs + XW'(4)))
                    begin
                        port1_next = {port1_reg[7:0], b};
                    end
                    else if ((idx == l4_ofs + XW'(efc_pkg::TCP_DOFF_OFS)) &&
                             (proto_reg == efc_pkg::IPP_TCP))
                    begin
                        pstart_next = efc_pkg::PSTART_W'(l4_ofs) +
                                      {2'b00, b[7:4], 2'b00};
                    end
                end
            end
        end
    end

    efc_token_search u_token_search
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .search_en (search_en),
        .frame_end (frame_end),
        .data      (b),
        .found_now (found_now)
    );

    assign snap_valid_next = frame_end ? 1'b1 : (snap_ready ? 1'b0 : snap_valid_reg);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_byte_reg <= byte_in.frame_byte;
            in_last_reg <= byte_in.last_byte;
        end
    end

    // Header state, cleared once the frame is handed over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            mac0_reg   <= '0;
            mac1_reg   <= '0;
            ether_reg  <= '0;
            hdr_reg    <= '0;
            proto_reg  <= '0;
            addr0_reg  <= '0;
            addr1_reg  <= '0;
            port0_reg  <= '0;
            port1_reg  <= '0;
            pstart_reg <= '0;
        end
        else if (frame_end)
        begin
            count_reg  <= '0;
            mac0_reg   <= '0;
            mac1_reg   <= '0;
            ether_reg  <= '0;
            hdr_reg    <= '0;
            proto_reg  <= '0;
            addr0_reg  <= '0;
            addr1_reg  <= '0;
            port0_reg  <= '0;
            port1_reg  <= '0;
            pstart_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            mac0_reg   <= mac0_next;
            mac1_reg   <= mac1_next;
            ether_reg  <= ether_next;
            hdr_reg    <= hdr_next;
            proto_reg  <= proto_next;
            addr0_reg  <= addr0_next;
            addr1_reg  <= addr1_next;
            port0_reg  <= port0_next;
            port1_reg  <= port1_next;
            pstart_reg <= pstart_next;
        end
    end

    // Frame snapshot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_end)
        begin
            snap_len_reg                <= count_next;
            snap_info_reg.dest_mac      <= mac0_next;
            snap_info_reg.source_mac    <= mac1_next;
            snap_info_reg.type_field    <= ether_next;
            snap_info_reg.ip_hdr_bytes  <= hdr_next;
            snap_info_reg.ip_protocol   <= proto_next;
            snap_info_reg.src_addr      <= addr0_next;
            snap_info_reg.dst_addr      <= addr1_next;
            snap_info_reg.src_port      <= port0_next;
            snap_info_reg.dst_port      <= port1_next;
            snap_info_reg.payload_start <= pstart_next;
            snap_info_reg.token_found   <= found_now;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_info  = snap_info_reg;
    assign snap_len   = snap_len_reg;

endmodule

### hdl/efc_classifier.sv
// ----------------------------------------------------------------------------
// efc_classifier
// Decides the frame class from the snapshot and holds the result beat.
// ----------------------------------------------------------------------------
module efc_classifier
#(
    parameter int MAX_FRAME_BYTES = efc_pkg::MAX_FRAME_BYTES_DEF,
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        snap_valid,
    input  efc_pkg::frame_info_t        snap_info,
    input  logic [CW-1:0]               snap_len,
    output logic                        snap_ready,
    input  logic [efc_pkg::PORT_W-1:0]  http_port,
    input  logic [efc_pkg::PORT_W-1:0]  dns_port,
    efc_result_if.source                result_out
);

    localparam int XW = (CW > 12) ? CW : 13;

    logic [XW-1:0] len_x;
    logic [XW-1:0] l4_ofs;
    logic [XW-1:0] pstart_x;
    logic [XW-1:0] app_x;
    logic [XW-1:0] app_diff;
    logic          ip_ok;
    logic          http_hit;
    logic          dns_hit;
    logic [efc_pkg::CLASS_W-1:0] cls;
    logic          load;

    // Result register
    logic                         res_valid_reg;
    logic                         res_valid_next;
    logic [efc_pkg::CLASS_W-1:0]  class_reg;
    logic [efc_pkg::MAC_W-1:0]    dmac_reg;
    logic [efc_pkg::MAC_W-1:0]    smac_reg;
    logic [efc_pkg::ETYPE_W-1:0]  etype_reg;
    logic [efc_pkg::IP_W-1:0]     sip_reg;
    logic [efc_pkg::IP_W-1:0]     dip_reg;
    logic [efc_pkg::LEN_W-1:0]    flen_reg;
    logic [efc_pkg::LEN_W-1:0]    alen_reg;

    assign snap_ready = !res_valid_reg || result_out.ready;
    assign load       = snap_valid && snap_ready;

    assign len_x    = XW'(snap_len);
    assign l4_ofs   = XW'(efc_pkg::ETH_HDR_LEN) + XW'(snap_info.ip_hdr_bytes);
    assign pstart_x = XW'(snap_info.payload_start);
    assign app_diff = len_x - pstart_x;
    assign ip_ok    = (len_x > XW'(efc_pkg::ETH_HDR_LEN)) &&
                      (snap_info.type_field == efc_pkg::ETH_IPV4) &&
                      (snap_info.ip_hdr_bytes >= efc_pkg::HDR_W'(efc_pkg::IP_MIN_HDR));
    assign http_hit = (snap_info.src_port == http_port) || (snap_info.dst_port == http_port);
    assign dns_hit  = (snap_info.src_port == dns_port) || (snap_info.dst_port == dns_port);

    // Class decision
    always_comb
    begin
        cls   = efc_pkg::CLASS_DROP;
        app_x = '0;
        if ((len_x >= XW'(efc_pkg::ETH_HDR_LEN)) && (snap_info.type_field == efc_pkg::ETH_ARP))
        begin
            if (len_x >= XW'(efc_pkg::ARP_MIN_LEN))
            begin
                cls = efc_pkg::CLASS_ARP;
            end
        end
        else if (ip_ok)
        begin
            case (snap_info.ip_protocol)
                efc_pkg::IPP_ICMP:
                begin
                    if (len_x >= l4_ofs + XW'(efc_pkg::L4_SHORT_LEN))
                    begin
                        cls = efc_pkg::CLASS_ICMP;
                    end
                end
                efc_pkg::IPP_UDP:
                begin
                    if (len_x >= l4_ofs + XW'(efc_pkg::L4_SHORT_LEN))
                    begin
                        cls = dns_hit ? efc_pkg::CLASS_DNS : efc_pkg::CLASS_UDP;
                    end
                end
                efc_pkg::IPP_TCP:
                begin
                    if ((len_x >= l4_ofs + XW'(efc_pkg::TCP_MIN_HDR)) &&
                        (pstart_x >= l4_ofs + XW'(efc_pkg::TCP_MIN_HDR)))
                    begin
                        cls = efc_pkg::CLASS_TCP;
                        if (http_hit && snap_info.token_found && (len_x >= pstart_x))
                        begin
                            cls   = efc_pkg::CLASS_HTTP;
                            app_x = app_diff;
                        end
                    end
                end
                default:
                begin
                    cls = efc_pkg::CLASS_DROP;
                end
            endcase
        end
    end

    assign res_valid_next = load ? 1'b1 : (result_out.ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload, held while the beat waits
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            class_reg <= cls;
            dmac_reg  <= snap_info.dest_mac;
            smac_reg  <= snap_info.source_mac;
            etype_reg <= snap_info.type_field;
            sip_reg   <= (cls != efc_pkg::CLASS_DROP) ? snap_info.src_addr : '0;
            dip_reg   <= (cls != efc_pkg::CLASS_DROP) ? snap_info.dst_addr : '0;
            flen_reg  <= (len_x > XW'(efc_pkg::LEN_SAT)) ? efc_pkg::LEN_W'(efc_pkg::LEN_SAT)
                                                         : len_x[efc_pkg::LEN_W-1:0];
            alen_reg  <= (app_x > XW'(efc_pkg::LEN_SAT)) ? efc_pkg::LEN_W'(efc_pkg::LEN_SAT)
                                                         : app_x[efc_pkg::LEN_W-1:0];
        end
    end

    assign result_out.valid        = res_valid_reg;
    assign result_out.pkt_class    = class_reg;
    assign result_out.dest_mac     = dmac_reg;
    assign result_out.source_mac   = smac_reg;
    assign result_out.type_field   = etype_reg;
    assign result_out.source_ip    = sip_reg;
    assign result_out.dest_ip      = dip_reg;
    assign result_out.frame_length = flen_reg;
    assign result_out.app_length   = alen_reg;

endmodule

### hdl/ethernet_frame_classifier_core.sv
// ----------------------------------------------------------------------------
// ethernet_frame_classifier_core
// Byte-wide Ethernet/ARP/IPv4 header parser with TCP/UDP/HTTP/DNS classing.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while not stalled, with no gaps needed
// between frames, and gives one result beat per frame. A frame's final byte
// passes through the input register and the frame snapshot before the result
// register is loaded. Per-byte header capture and the four HTTP token
// matchers sit between the input register and the snapshot; the class
// decision sits in front of the result register. Input stalls only when the
// final byte of a frame finds the snapshot full and the result register full
// and not taken. The HTTP and DNS port registers are written through
// cfg_we/cfg_index/cfg_data and must be changed only while no frame is in
// flight. Frames longer than MAX_FRAME_BYTES stop being parsed at that
// count; reported lengths saturate at 4095.
module ethernet_frame_classifier_core
#(
    parameter int MAX_FRAME_BYTES = efc_pkg::MAX_FRAME_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [efc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [efc_pkg::CFG_DATA_W-1:0] cfg_data,
    efc_byte_if.sink                       byte_in,
    efc_result_if.source                   result_out
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

    logic [efc_pkg::PORT_W-1:0] http_port_reg;
    logic [efc_pkg::PORT_W-1:0] dns_port_reg;

    logic                 snap_valid;
    logic                 snap_ready;
    efc_pkg::frame_info_t snap_info;
    logic [CW-1:0]        snap_len;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            http_port_reg <= efc_pkg::HTTP_PORT_RST;
            dns_port_reg  <= efc_pkg::DNS_PORT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                efc_pkg::CFG_HTTP_PORT: http_port_reg <= cfg_data;
                efc_pkg::CFG_DNS_PORT:  dns_port_reg  <= cfg_data;
                default:
                begin
                    http_port_reg <= http_port_reg;
                end
            endcase
        end
    end

    efc_field_capture #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_field_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .snap_ready (snap_ready),
        .snap_valid (snap_valid),
        .snap_info  (snap_info),
        .snap_len   (snap_len)
    );

    efc_classifier #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_classifier (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_info  (snap_info),
        .snap_len   (snap_len),
        .snap_ready (snap_ready),
        .http_port  (http_port_reg),
        .dns_port   (dns_port_reg),
        .result_out (result_out)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Ethernet frame classifier core.
// Frames are fed byte by byte through the input channel while a predictor
// follows each accepted beat and keeps the expected verdict of every frame.
// Each result beat is compared field by field with the oldest verdict.
// The run starts with hand-built frames for every class but plain UDP, and
// for short and malformed cases, then goes through several port settings
// with two random frames each. Either channel side may idle at random.
// ----------------------------------------------------------------------------
module tb;
    import efc_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int CYCLE_LIMIT = 600000;

    typedef logic [7:0] octet_t;

    typedef struct packed {
        logic       last;
        octet_t     octet;
    } byte_beat_t;

    typedef struct packed {
        logic [CLASS_W-1:0] pkt_class;
        logic [MAC_W-1:0]   dest_mac;
        logic [MAC_W-1:0]   source_mac;
        logic [ETYPE_W-1:0] type_field;
        logic [IP_W-1:0]    source_ip;
        logic [IP_W-1:0]    dest_ip;
        logic [LEN_W-1:0]   frame_length;
        logic [LEN_W-1:0]   app_length;
    } frame_verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    efc_byte_if   byte_ch ();
    efc_result_if res_ch ();

    ethernet_frame_classifier_core uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_in    (byte_ch),
        .result_out (res_ch)
    );

    // Stimulus and scoreboard storage
    byte_beat_t     byte_pending_q [$];
    frame_verdict_t verdict_q [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fails = 0;
    int bytes_sent = 0;
    int frames_checked = 0;
    int port_settings = 1;
    int cycle_cnt = 0;
    int class_seen [8];

    // Predictor copy of the port registers
    logic [PORT_W-1:0] rx_http_port = HTTP_PORT_RST;
    logic [PORT_W-1:0] rx_dns_port = DNS_PORT_RST;

    // Predictor per-frame state
    int          cnt_bytes;
    logic [47:0] cap_dmac, cap_smac;
    logic [15:0] cap_etype;
    int          cap_ihl;
    logic [7:0]  cap_proto;
    logic [31:0] cap_addr_a, cap_addr_b;
    logic [15:0] cap_port_a, cap_port_b;
    int          cap_pay_off;
    int          tok_pos [4];
    bit          saw_nul, saw_token;

    string http_words [4] = '{"GET", "POST", "HTTP/1.1", "HTTP/1.0"};
    string frags [10] = '{"GET", "POST", "HTTP/1.1", "HTTP/1.0", "GE", "PPOS",
                          "HTTP/1.", "HTTP/1.2", "GGET", "HHTTP/1.0"};
    string char_pool = "GETPOSHT/10. ";

    // Clock
    always #HALF_PERIOD clk = ~clk;

    function automatic void clear_frame();
        cnt_bytes = 0;
        cap_dmac = '0;
        cap_smac = '0;
        cap_etype = '0;
        cap_ihl = 0;
        cap_proto = '0;
        cap_addr_a = '0;
        cap_addr_b = '0;
        cap_port_a = '0;
        cap_port_b = '0;
        cap_pay_off = 0;
        for (int k = 0; k < 4; k++)
            tok_pos[k] = 0;
        saw_nul = 1'b0;
        saw_token = 1'b0;
    endfunction

    // Follow one accepted byte; on the final byte queue the frame verdict
    function automatic void classify_step(input octet_t b, input logic last);
        frame_verdict_t v;
        int             i, l4, p;
        if (cnt_bytes < MAX_FRAME_BYTES_DEF)
        begin
            i = cnt_bytes;
            l4 = ETH_HDR_LEN + cap_ihl;
            if (i < MAC_DST_END)
                cap_dmac = {cap_dmac[39:0], b};
            else if (i < MAC_SRC_END)
                cap_smac = {cap_smac[39:0], b};
            else if (i < ETH_HDR_LEN)
                cap_etype = {cap_etype[7:0], b};
            else if (cap_etype == ETH_ARP)
            begin
                if (i >= ARP_SPA_LO && i < ARP_SPA_HI)
                    cap_addr_a = {cap_addr_a[23:0], b};
                else if (i >= ARP_TPA_LO && i < ARP_TPA_HI)
                    cap_addr_b = {cap_addr_b[23:0], b};
            end
            else if (cap_etype == ETH_IPV4)
            begin
                if (i == ETH_HDR_LEN)
                    cap_ihl = int'(b[3:0]) * 4;
                else if (i == IP_PROTO_OFS)
                    cap_proto = b;
                else if (i >= IP_SRC_LO && i < IP_SRC_HI)
                    cap_addr_a = {cap_addr_a[23:0], b};
                else if (i >= IP_SRC_HI && i < IP_DST_HI)
                    cap_addr_b = {cap_addr_b[23:0], b};
                if (i > ETH_HDR_LEN && cap_ihl >= IP_MIN_HDR)
                begin
                    if (i >= l4 && i < l4 + 2)
                        cap_port_a = {cap_port_a[7:0], b};
                    else if (i >= l4 + 2 && i < l4 + 4)
                        cap_port_b = {cap_port_b[7:0], b};
                    else if (i == l4 + TCP_DOFF_OFS && cap_proto == IPP_TCP)
                        cap_pay_off = l4 + int'(b[7:4]) * 4;
                    // token search over the TCP payload up to the first zero byte
                    if (cap_proto == IPP_TCP && i > l4 + TCP_DOFF_OFS &&
                        cap_pay_off >= l4 + TCP_MIN_HDR && i >= cap_pay_off && !saw_nul)
                    begin
                        if (b == 8'h00)
                            saw_nul = 1'b1;
                        else
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                p = tok_pos[k];
                                if (p < http_words[k].len() && b == http_words[k][p])
                                begin
                                    p++;
                                    if (p >= http_words[k].len())
                                    begin
                                        saw_token = 1'b1;
                                        p = 0;
                                    end
                                end
                                else
                                    p = (b == http_words[k][0]) ? 1 : 0;
                                tok_pos[k] = p;
                            end
                        end
                    end
                end
            end
            cnt_bytes++;
        end
        if (!last)
            return;

        // Classify the finished frame
        v = '0;
        v.pkt_class = CLASS_DROP;
        l4 = ETH_HDR_LEN + cap_ihl;
        if (cnt_bytes >= ETH_HDR_LEN && cap_etype == ETH_ARP)
        begin
            if (cnt_bytes >= ARP_MIN_LEN)
                v.pkt_class = CLASS_ARP;
        end
        else if (cnt_bytes > ETH_HDR_LEN && cap_etype == ETH_IPV4 && cap_ihl >= IP_MIN_HDR)
        begin
            case (cap_proto)
                IPP_ICMP:
                    if (cnt_bytes >= l4 + L4_SHORT_LEN)
                        v.pkt_class = CLASS_ICMP;
                IPP_UDP:
                    if (cnt_bytes >= l4 + L4_SHORT_LEN)
                        v.pkt_class = (cap_port_a == rx_dns_port || cap_port_b == rx_dns_port)
                                      ? CLASS_DNS : CLASS_UDP;
                IPP_TCP:
                    if (cnt_bytes >= l4 + TCP_MIN_HDR && cap_pay_off >= l4 + TCP_MIN_HDR)
                    begin
                        v.pkt_class = CLASS_TCP;
                        if ((cap_port_a == rx_http_port || cap_port_b == rx_http_port) &&
                            saw_token && cnt_bytes >= cap_pay_off)
                        begin
                            v.pkt_class = CLASS_HTTP;
                            v.app_length = LEN_W'(cnt_bytes - cap_pay_off);
                        end
                    end
                default: ;
            endcase
        end
        v.dest_mac = cap_dmac;
        v.source_mac = cap_smac;
        v.type_field = cap_etype;
        if (v.pkt_class != CLASS_DROP)
        begin
            v.source_ip = cap_addr_a;
            v.dest_ip = cap_addr_b;
        end
        v.frame_length = LEN_W'(cnt_bytes);
        verdict_q = {verdict_q, v};
        clear_frame();
    endfunction

    // ------------------------------------------------------------------------
    // Frame building
    // ------------------------------------------------------------------------
    function automatic logic [47:0] rand_mac();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [15:0] pick_port();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return rx_http_port;
        else if (r < 45)
            return rx_dns_port;
        else if (r < 55)
            return ($urandom_range(1) != 0) ? HTTP_PORT_RST : DNS_PORT_RST;
        return 16'($urandom);
    endfunction

    task automatic put_octet(ref octet_t f[$], input octet_t b);
        f = {f, b};
    endtask

    task automatic trim(ref octet_t f[$], input int n);
        while (f.size() > n)
            void'(f.pop_back());
    endtask

    task automatic put_text(ref octet_t f[$], input string s);
        for (int k = 0; k < s.len(); k++)
            put_octet(f, s[k]);
    endtask

    task automatic put_eth(ref octet_t f[$], input logic [47:0] dmac, input logic [47:0] smac,
                           input logic [15:0] et);
        f.delete();
        for (int k = 5; k >= 0; k--)
            put_octet(f, dmac[k*8 +: 8]);
        for (int k = 5; k >= 0; k--)
            put_octet(f, smac[k*8 +: 8]);
        put_octet(f, et[15:8]);
        put_octet(f, et[7:0]);
    endtask

    // ARP body: sender protocol address at 28, target at 38
    task automatic put_arp(ref octet_t f[$], input logic [31:0] spa, input logic [31:0] tpa);
        repeat (14) put_octet(f, 8'($urandom));
        for (int k = 3; k >= 0; k--)
            put_octet(f, spa[k*8 +: 8]);
        repeat (6) put_octet(f, 8'($urandom));
        for (int k = 3; k >= 0; k--)
            put_octet(f, tpa[k*8 +: 8]);
    endtask

    // Full IPv4 frame head up to the transport payload; malformed lengths keep
    // the minimal layout
    task automatic put_ipv4(ref octet_t f[$], input int ihl, input logic [7:0] proto,
                            input logic [15:0] sp, input logic [15:0] dp, input int doff);
        int          hb, th;
        logic [31:0] sa, da;
        hb = (ihl < 5) ? IP_MIN_HDR : ihl * 4;
        th = (doff < 5) ? TCP_MIN_HDR : doff * 4;
        sa = $urandom;
        da = $urandom;
        put_eth(f, rand_mac(), rand_mac(), ETH_IPV4);
        put_octet(f, {($urandom_range(9) == 0) ? 4'($urandom) : 4'h4, 4'(ihl)});
        for (int k = 1; k < hb; k++)
        begin
            if (k == 9)
                put_octet(f, proto);
            else if (k >= 12 && k < 16)
                put_octet(f, sa[(15-k)*8 +: 8]);
            else if (k >= 16 && k < 20)
                put_octet(f, da[(19-k)*8 +: 8]);
            else
                put_octet(f, 8'($urandom));
        end
        put_octet(f, sp[15:8]);
        put_octet(f, sp[7:0]);
        put_octet(f, dp[15:8]);
        put_octet(f, dp[7:0]);
        if (proto == IPP_TCP)
        begin
            for (int k = 4; k < th; k++)
                put_octet(f, (k == TCP_DOFF_OFS) ? {4'(doff), 4'($urandom)} : 8'($urandom));
        end
        else
            repeat (4) put_octet(f, 8'($urandom));
    endtask

    task automatic queue_frame(ref octet_t f[$]);
        byte_beat_t bb;
        for (int k = 0; k < f.size(); k++)
        begin
            bb.last = (k == f.size() - 1);
            bb.octet = f[k];
            byte_pending_q = {byte_pending_q, bb};
        end
    endtask

    // Random frames: mostly well-formed IPv4 with varied ports and payloads,
    // plus ARP, runts, foreign ethertypes and truncated frames
    task automatic queue_random_phase(input int min_frames);
        octet_t     f[$];
        int         made, r, seg, ihl, doff;
        logic [7:0] proto;
        made = 0;
        while (made < min_frames)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                f.delete();
                repeat ($urandom_range(13, 1)) put_octet(f, 8'($urandom));
            end
            else if (r < 22)
            begin
                put_eth(f, rand_mac(), rand_mac(), ETH_ARP);
                put_arp(f, $urandom, $urandom);
                repeat ($urandom_range(6, 0)) put_octet(f, 8'($urandom));
                if ($urandom_range(4) == 0)
                    trim(f, $urandom_range(41, 14));
            end
            else if (r < 30)
            begin
                put_eth(f, rand_mac(), rand_mac(), 16'($urandom));
                repeat ($urandom_range(40, 0)) put_octet(f, 8'($urandom));
            end
            else
            begin
                r = $urandom_range(99);
                ihl = (r < 85) ? 5 : (r < 95) ? $urandom_range(15, 6) : $urandom_range(4, 0);
                r = $urandom_range(99);
                doff = (r < 85) ? 5 : (r < 95) ? $urandom_range(15, 6) : $urandom_range(4, 0);
                r = $urandom_range(99);
                proto = (r < 15) ? IPP_ICMP : (r < 45) ? IPP_UDP : (r < 90) ? IPP_TCP
                        : 8'($urandom);
                put_ipv4(f, ihl, proto, pick_port(), pick_port(), doff);
                repeat ($urandom_range(4, 0))
                begin
                    seg = $urandom_range(99);
                    if (seg < 45)
                        put_text(f, frags[$urandom_range(9)]);
                    else if (seg < 85)
                        put_octet(f, char_pool[$urandom_range(char_pool.len() - 1)]);
                    else if (seg < 93)
                        put_octet(f, 8'($urandom_range(255, 1)));
                    else
                        put_octet(f, 8'h00);
                end
                if ($urandom_range(6) == 0)
                    trim(f, $urandom_range(f.size(), 14));
            end
            queue_frame(f);
            made++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Port register writes and idle waits
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PORT_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_HTTP_PORT)
            rx_http_port = val;
        else
            rx_dns_port = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every queued beat is taken and every verdict checked
    task automatic settle();
        while (byte_pending_q.size() != 0 || byte_ch.valid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued beats, holds each until taken
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drv
        byte_beat_t nxt;
        if (!rst_n)
            byte_ch.valid <= 1'b0;
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                classify_step(byte_ch.frame_byte, byte_ch.last_byte);
                bytes_sent++;
            end
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (byte_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = byte_pending_q.pop_front();
                    byte_ch.valid <= 1'b1;
                    byte_ch.frame_byte <= nxt.octet;
                    byte_ch.last_byte <= nxt.last;
                end
                else
                    byte_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure, compare each result beat
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: frame %0d %s expected %h got %h", $time, frames_checked, name,
                     want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin : mon
        frame_verdict_t want;
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: result beat with no frame outstanding, class %0d", $time,
                         res_ch.pkt_class);
                fails++;
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("pkt_class", 64'(want.pkt_class), 64'(res_ch.pkt_class));
                check_field("dest_mac", 64'(want.dest_mac), 64'(res_ch.dest_mac));
                check_field("source_mac", 64'(want.source_mac), 64'(res_ch.source_mac));
                check_field("type_field", 64'(want.type_field), 64'(res_ch.type_field));
                check_field("source_ip", 64'(want.source_ip), 64'(res_ch.source_ip));
                check_field("dest_ip", 64'(want.dest_ip), 64'(res_ch.dest_ip));
                check_field("frame_length", 64'(want.frame_length),
                            64'(res_ch.frame_length));
                check_field("app_length", 64'(want.app_length), 64'(res_ch.app_length));
                class_seen[want.pkt_class]++;
                frames_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: no finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stim
        octet_t            f[$];
        logic [PORT_W-1:0] hp, dp;

        byte_ch.valid = 1'b0;
        byte_ch.frame_byte = '0;
        byte_ch.last_byte = 1'b0;
        res_ch.ready = 1'b0;
        for (int k = 0; k < 8; k++)
            class_seen[k] = 0;
        clear_frame();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset port values, sender busy, receiver slow
        send_idle_pct = 16;
        recv_stall_pct = 88;

        // runts: one byte, one short of the Ethernet header, bare header
        f.delete();
        put_octet(f, 8'hFF);
        queue_frame(f);
        put_eth(f, '1, '0, ETH_IPV4);
        trim(f, ETH_HDR_LEN - 1);
        queue_frame(f);
        put_eth(f, '0, '1, ETH_IPV4);
        queue_frame(f);

        // ARP: exact minimum, one byte short
        put_eth(f, '0, '1, ETH_ARP);
        put_arp(f, '1, '0);
        queue_frame(f);
        put_eth(f, rand_mac(), rand_mac(), ETH_ARP);
        put_arp(f, $urandom, $urandom);
        trim(f, ARP_MIN_LEN - 1);
        queue_frame(f);

        // ICMP at exact minimum
        put_ipv4(f, 5, IPP_ICMP, 16'hFFFF, 16'h0000, 5);
        queue_frame(f);

        // UDP: DNS on either port, truncated
        put_ipv4(f, 5, IPP_UDP, 16'h0000, DNS_PORT_RST, 5);
        queue_frame(f);
        put_ipv4(f, 5, IPP_UDP, DNS_PORT_RST, 16'hFFFF, 5);
        queue_frame(f);
        put_ipv4(f, 5, IPP_UDP, DNS_PORT_RST, DNS_PORT_RST, 5);
        trim(f, 41);
        queue_frame(f);

        // TCP with the HTTP port: tokens, near misses, zero byte first
        put_ipv4(f, 5, IPP_TCP, 16'd40000, HTTP_PORT_RST, 5);
        put_text(f, "GET /");
        queue_frame(f);
        put_ipv4(f, 5, IPP_TCP, HTTP_PORT_RST, 16'd40000, 5);
        put_text(f, "HTTP/1.0");
        queue_frame(f);
        put_ipv4(f, 5, IPP_TCP, 16'd1, HTTP_PORT_RST, 5);
        put_text(f, "xPPOST");
        queue_frame(f);
        put_ipv4(f, 5, IPP_TCP, 16'd2, HTTP_PORT_RST, 5);
        put_text(f, "HTTP/1.2");
        queue_frame(f);
        put_ipv4(f, 5, IPP_TCP, 16'd3, HTTP_PORT_RST, 5);
        put_octet(f, 8'h00);
        put_text(f, "GET");
        queue_frame(f);
        // token present but on another port
        put_ipv4(f, 5, IPP_TCP, 16'd8080, 16'd8081, 5);
        put_text(f, "GET");
        queue_frame(f);

        // malformed header lengths, longest headers with options
        put_ipv4(f, 5, IPP_TCP, 16'd5, HTTP_PORT_RST, 4);
        put_text(f, "GET");
        queue_frame(f);
        put_ipv4(f, 4, IPP_UDP, 16'd5, 16'd6, 5);
        queue_frame(f);
        put_ipv4(f, 15, IPP_TCP, HTTP_PORT_RST, HTTP_PORT_RST, 15);
        put_text(f, "POST");
        queue_frame(f);
        // payload offset beyond the frame end, token text inside the options
        put_ipv4(f, 5, IPP_TCP, HTTP_PORT_RST, 16'd7, 15);
        f[54] = "G";
        f[55] = "E";
        f[56] = "T";
        trim(f, 59);
        queue_frame(f);

        // unknown protocol and unknown ethertype
        put_ipv4(f, 5, 8'd47, 16'd8, 16'd9, 5);
        repeat (2) put_octet(f, 8'($urandom));
        queue_frame(f);
        put_eth(f, rand_mac(), rand_mac(), 16'h86DD);
        repeat (4) put_octet(f, 8'($urandom));
        queue_frame(f);

        settle();

        // Random phases, each under its own port setting
        for (int ph = 1; ph <= 5; ph++)
        begin
            case (ph)
                1:
                begin
                    hp = 16'hFFFF;
                    dp = 16'h0000;
                end
                2:
                begin
                    hp = 16'h0000;
                    dp = 16'hFFFF;
                end
                4:
                begin
                    hp = HTTP_PORT_RST;
                    dp = DNS_PORT_RST;
                end
                default:
                begin
                    hp = 16'($urandom);
                    dp = 16'($urandom);
                end
            endcase
            write_reg(CFG_HTTP_PORT, hp);
            write_reg(CFG_DNS_PORT, dp);
            port_settings++;
            if (ph == 1)
            begin
                send_idle_pct = 16;
                recv_stall_pct = 88;
            end
            else if (ph <= 3)
            begin
                send_idle_pct = 88;
                recv_stall_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            queue_random_phase(2);
            settle();
        end

        $display("Checked %0d frames (%0d bytes) under %0d port settings.", frames_checked,
                 bytes_sent, port_settings);
        $display("Classes: dropped %0d, ARP %0d, ICMP %0d, TCP %0d, UDP %0d, HTTP %0d, DNS %0d",
                 class_seen[CLASS_DROP], class_seen[CLASS_ARP], class_seen[CLASS_ICMP],
                 class_seen[CLASS_TCP], class_seen[CLASS_UDP], class_seen[CLASS_HTTP],
                 class_seen[CLASS_DNS]);
        if (fails == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
